/* sv/pbsd_pkg.sv */
// types, constants and reset state shared by the string field decoder
package pbsd_pkg;

  // sizing of the stored strings and argument slots
  localparam int MAX_ARGS     = 8;
  localparam int MODULE_CHARS = 64;
  localparam int ARG_CHARS    = 64;
  localparam int ARG_CNT_W    = $clog2(MAX_ARGS + 1);
  localparam int ARG_IDX_W    = 3;
  localparam int POS_W        = 6;
  localparam int VARINT_MAX   = 5;

  // protobuf field numbers and wire type
  localparam logic [2:0]  WIRE_LEN     = 3'd2;
  localparam logic [28:0] FIELD_MODULE = 29'd1;
  localparam logic [28:0] FIELD_ARG    = 29'd2;

  typedef enum logic [2:0] {
    PH_TAG = 3'b001,
    PH_LEN = 3'b010,
    PH_VAL = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    TK_SKIP   = 2'd0,
    TK_MODULE = 2'd1,
    TK_ARG    = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                 char_valid;
    logic                 to_arg;
    logic [ARG_IDX_W-1:0] arg_index;
    logic [POS_W-1:0]     char_pos;
    logic [7:0]           char_value;
    logic                 string_end;
    logic [POS_W-1:0]     string_len;
    logic                 msg_done;
    logic                 msg_ok;
    logic [ARG_CNT_W-1:0] arg_count;
  } out_t;

  typedef struct packed {
    phase_t               phase;
    logic [31:0]          varint_acc;
    logic [2:0]           varint_bytes;
    kind_t                target_kind;
    logic [31:0]          bytes_left;
    logic [POS_W-1:0]     pos_count;
    logic [ARG_CNT_W-1:0] args_stored;
    logic                 module_nonempty;
    logic                 failed;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    phase:           PH_TAG,
    varint_acc:      32'd0,
    varint_bytes:    3'd0,
    target_kind:     TK_SKIP,
    bytes_left:      32'd0,
    pos_count:       '0,
    args_stored:     '0,
    module_nonempty: 1'b0,
    failed:          1'b0
  };

endpackage

/* sv/protobuf_string_field_decoder_core.sv */
// top level of the protobuf string field decoder
//
// Usage: message bytes enter on the in_ channel (valid/ready), one byte per
// request, with last_byte set on the final byte of each message. Every input
// request produces exactly one result request on the out_ channel: character
// stores for the module string or an argument slot, string-end marks with the
// truncated length, and on the last byte msg_done with the msg_ok verdict.
// The result of a byte is registered and is valid in the cycle after the byte
// is accepted. Throughput is one byte per cycle; the parser state update
// is a single combinational pass from the parser registers to the result
// register, so nothing limits the rate but the output handshake.
// Reset (rst_n low, synchronous) puts the parser at the start of a message
// and empties the result register.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken; in_ready is high whenever the output
// register is empty or being emptied in the same cycle.
module protobuf_string_field_decoder_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pbsd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pbsd_pkg::out_t out_data
);
  import pbsd_pkg::*;

  dec_state_t state_r;
  dec_state_t state_nxt;
  out_t       out_r;
  out_t       out_nxt;
  logic       out_valid_r;
  logic       in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // per-byte parser logic
  pbsd_step u_step (
    .st  (state_r),
    .req (in_data),
    .nxt (state_nxt),
    .res (out_nxt)
  );

  // parser state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

  // a held result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("request accepted while result stalled");

  // every accepted request leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  // the last byte returns the parser to a clean message start
  a_msg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_byte) |=>
      (state_r.phase == PH_TAG && state_r.args_stored == '0 && !state_r.failed))
    else $error("parser not cleared after last byte");

  // verdict only with message end
  a_ok_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.msg_ok) |-> out_r.msg_done)
    else $error("msg_ok without msg_done");

endmodule

/* sv/pbsd_step.sv */
// per-byte parser update: next decoder state and the result for one request
module pbsd_step (
  input  pbsd_pkg::dec_state_t st,
  input  pbsd_pkg::in_t        req,
  output pbsd_pkg::dec_state_t nxt,
  output pbsd_pkg::out_t       res
);
  import pbsd_pkg::*;

  logic [31:0] shifted;
  logic [31:0] acc_or;
  logic        cap_ok;
  logic        finish;

  // place the payload bits of this varint byte (seven, or the low four in the fifth byte)
  always_comb begin
    unique case (st.varint_bytes)
      3'd0:    shifted = {25'd0, req.byte_in[6:0]};
      3'd1:    shifted = {18'd0, req.byte_in[6:0], 7'd0};
      3'd2:    shifted = {11'd0, req.byte_in[6:0], 14'd0};
      3'd3:    shifted = {4'd0, req.byte_in[6:0], 21'd0};
      3'd4:    shifted = {req.byte_in[3:0], 28'd0};
      default: shifted = 32'd0;
    endcase
  end

  assign acc_or = st.varint_acc | shifted;

  // room left in the destination string
  always_comb begin
    if (st.target_kind == TK_MODULE) begin
      cap_ok = {1'b0, st.pos_count} < (POS_W + 1)'(MODULE_CHARS - 1);
    end else begin
      cap_ok = {1'b0, st.pos_count} < (POS_W + 1)'(ARG_CHARS - 1);
    end
  end

  // parser state update and result fields
  always_comb begin
    nxt    = st;
    res    = '0;
    finish = 1'b0;
    if (!st.failed) begin
      if (st.phase != PH_VAL) begin
        nxt.varint_acc = acc_or;
        if (req.byte_in[7]) begin
          if (st.varint_bytes >= 3'(VARINT_MAX - 1)) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.varint_bytes = st.varint_bytes + 3'd1;
          end
        end else if (st.phase == PH_TAG) begin
          if (acc_or[2:0] != WIRE_LEN) begin
            nxt.failed = 1'b1;
          end else begin
            if (acc_or[31:3] == FIELD_MODULE) begin
              nxt.target_kind = TK_MODULE;
            end else if (acc_or[31:3] == FIELD_ARG &&
                         st.args_stored < ARG_CNT_W'(MAX_ARGS)) begin
              nxt.target_kind = TK_ARG;
            end else begin
              nxt.target_kind = TK_SKIP;
            end
            nxt.phase = PH_LEN;
          end
          nxt.varint_acc   = 32'd0;
          nxt.varint_bytes = 3'd0;
        end else begin
          // length complete
          nxt.bytes_left   = acc_or;
          nxt.varint_acc   = 32'd0;
          nxt.varint_bytes = 3'd0;
          nxt.pos_count    = '0;
          if (st.target_kind == TK_MODULE) begin
            nxt.module_nonempty = 1'b0;
          end
          if (acc_or == 32'd0) begin
            finish = 1'b1;
          end else begin
            nxt.phase = PH_VAL;
          end
        end
      end else begin
        // value byte
        if (st.target_kind != TK_SKIP && cap_ok) begin
          res.char_valid = 1'b1;
          res.char_pos   = st.pos_count;
          res.char_value = req.byte_in;
          if (st.target_kind == TK_MODULE && st.pos_count == '0) begin
            nxt.module_nonempty = |req.byte_in;
          end
          nxt.pos_count = st.pos_count + POS_W'(1);
        end
        nxt.bytes_left = st.bytes_left - 32'd1;
        if (st.bytes_left == 32'd1) begin
          finish = 1'b1;
        end
      end

      // destination while a stored string is read or ends
      if (nxt.target_kind != TK_SKIP && (nxt.phase == PH_VAL || finish)) begin
        res.to_arg = (nxt.target_kind == TK_ARG);
        if (nxt.target_kind == TK_ARG) begin
          res.arg_index = st.args_stored[ARG_IDX_W-1:0];
        end
      end

      // string completion
      if (finish) begin
        if (nxt.target_kind != TK_SKIP) begin
          res.string_end = 1'b1;
          res.string_len = nxt.pos_count;
          if (nxt.target_kind == TK_ARG) begin
            nxt.args_stored = st.args_stored + ARG_CNT_W'(1);
          end
        end
        nxt.phase       = PH_TAG;
        nxt.target_kind = TK_SKIP;
        nxt.pos_count   = '0;
      end
    end

    res.arg_count = nxt.args_stored;
    res.msg_done  = req.last_byte;

    // message end: verdict, then back to a clean state
    if (req.last_byte) begin
      res.msg_ok = !nxt.failed && nxt.phase == PH_TAG &&
                   nxt.varint_bytes == 3'd0 && nxt.module_nonempty;
      nxt = STATE_RESET;
    end
  end

endmodule
